// ===== hw/rtl/ntl_pkg.sv =====
// Shared types and constants for the name to task lookup table.
// Used by ntl_cell and name_to_task_lookup_table; depends on nothing.
package ntl_pkg;

  localparam logic CMD_LOOKUP   = 1'b0;
  localparam logic CMD_REGISTER = 1'b1;

  localparam int unsigned ID_W    = 8;
  localparam int unsigned RES_W   = 9;

  localparam logic signed [RES_W-1:0] MISS_ID = -9'sd1;

  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_REGISTER,
    OP_REFUSED
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic valid;
    op_e  op;
    logic hit;
    logic added;
  } ctl_t;

endpackage

// ===== hw/rtl/ntl_cell.sv =====
// One table entry of the lookup chain: holds a key and a task id and
// passes the request word on to its neighbor each cycle. Uses ntl_pkg.
module ntl_cell import ntl_pkg::*; #(
  parameter int unsigned KEY_W = 64,
  parameter int unsigned CNT_W = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ctl_t            ctl_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [ID_W-1:0]  id_i,
  input  logic [CNT_W-1:0] left_i,
  output ctl_t            ctl_o,
  output logic [KEY_W-1:0] key_o,
  output logic [ID_W-1:0]  id_o,
  output logic [CNT_W-1:0] left_o
);

  logic [KEY_W-1:0] entry_key_q;
  logic [ID_W-1:0]  entry_id_q;
  logic             live;
  logic             match;
  logic             append;
  ctl_t             ctl_d, ctl_q;
  logic [ID_W-1:0]  id_d, id_q;
  logic [KEY_W-1:0] key_q;
  logic [CNT_W-1:0] left_d, left_q;

  assign live   = (left_i != '0);
  assign match  = ctl_i.valid && live && !ctl_i.hit && (entry_key_q == key_i);
  assign append = ctl_i.valid && !live && !ctl_i.hit && (ctl_i.op == OP_REGISTER);

  always_comb begin
    ctl_d  = ctl_i;
    id_d   = id_i;
    left_d = live ? left_i - CNT_W'(1) : '0;
    if (match) begin
      ctl_d.hit = 1'b1;
      if (ctl_i.op == OP_LOOKUP) begin
        id_d = entry_id_q;
      end
    end
    if (append) begin
      ctl_d.hit   = 1'b1;
      ctl_d.added = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (append) begin
      entry_key_q <= key_i;
    end
    if (append || (match && ctl_i.op == OP_REGISTER)) begin
      entry_id_q <= id_i;
    end
    key_q  <= key_i;
    id_q   <= id_d;
    left_q <= left_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign key_o  = key_q;
  assign id_o   = id_q;
  assign left_o = left_q;

endmodule

// ===== hw/rtl/name_to_task_lookup_table.sv =====
// Name to task lookup table. Each request word (lookup or register) enters a
// chain of ENTRIES cells, one entry per cell, and moves one cell per cycle;
// the result is registered once the word leaves the last cell, and the next
// request is accepted the cycle after the result is taken, so only one
// request is in the chain at a time. Uses ntl_pkg and ntl_cell.
module name_to_task_lookup_table import ntl_pkg::*; #(
  parameter int unsigned ENTRIES    = 128,
  parameter int unsigned NAME_BYTES = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    cmd_i,
  input  logic [63:0]             name_key_i,
  input  logic [ID_W-1:0]         task_id_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    success_o,
  output logic signed [RES_W-1:0] found_id_o
);

  localparam int unsigned KEY_W = 8 * NAME_BYTES;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(ENTRIES);

  state_e state_q, state_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic success_q, success_d;
  logic signed [RES_W-1:0] found_q, found_d;
  logic accept;
  logic [KEY_W-1:0] canon_key;
  logic alive;

  ctl_t             ctl_w  [ENTRIES+1];
  logic [KEY_W-1:0] key_w  [ENTRIES+1];
  logic [ID_W-1:0]  id_w   [ENTRIES+1];
  logic [CNT_W-1:0] left_w [ENTRIES+1];

  always_comb begin
    canon_key = '0;
    alive     = 1'b1;
    for (int b = 0; b < NAME_BYTES; b++) begin
      if (name_key_i[8*b +: 8] == 8'h00) begin
        alive = 1'b0;
      end
      if (alive) begin
        canon_key[8*b +: 8] = name_key_i[8*b +: 8];
      end
    end
  end

  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    ctl_w[0]       = '0;
    ctl_w[0].valid = accept;
    if (cmd_i == CMD_LOOKUP) begin
      ctl_w[0].op = OP_LOOKUP;
    end else if (fill_q == FULL) begin
      ctl_w[0].op = OP_REFUSED;
    end else begin
      ctl_w[0].op = OP_REGISTER;
    end
  end

  assign key_w[0]  = canon_key;
  assign id_w[0]   = task_id_i;
  assign left_w[0] = fill_q;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    ntl_cell #(
      .KEY_W (KEY_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_w[i]),
      .key_i  (key_w[i]),
      .id_i   (id_w[i]),
      .left_i (left_w[i]),
      .ctl_o  (ctl_w[i+1]),
      .key_o  (key_w[i+1]),
      .id_o   (id_w[i+1]),
      .left_o (left_w[i+1])
    );
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    success_d   = success_q;
    found_d     = found_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (ctl_w[ENTRIES].valid) begin
          state_d = ST_OUT;
          found_d = MISS_ID;
          case (ctl_w[ENTRIES].op)
            OP_LOOKUP: begin
              success_d = ctl_w[ENTRIES].hit;
              if (ctl_w[ENTRIES].hit) begin
                found_d = $signed({1'b0, id_w[ENTRIES]});
              end
            end
            OP_REGISTER: begin
              success_d = 1'b1;
              if (ctl_w[ENTRIES].added) begin
                fill_d = fill_q + CNT_W'(1);
              end
            end
            default: begin
              success_d = 1'b0;
            end
          endcase
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    success_q <= success_d;
    found_q   <= found_d;
  end

  assign success_o  = success_q;
  assign found_id_o = found_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FULL)
    else $error("Entry count exceeds the table size.");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> (fill_q == $past(fill_q) + CNT_W'(1)))
    else $error("Entry count moved by more than one.");

  a_chain_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !ctl_w[ENTRIES].valid)
    else $error("Request word left the chain while idle.");

  a_hit_success: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_id_o[RES_W-1]) |-> success_o)
    else $error("Bound id given without success.");
`endif

endmodule
